/* rtl/lba_pkg.sv */
// ----------------------------------------------------------------------------
// lba_pkg: shared types and constants for the largest blob area block
// Holds the sequencer states, the neighbor offset decode and fixed widths.
// ----------------------------------------------------------------------------
package lba_pkg;

	localparam int CFG_W  = 9;
	localparam int AREA_W = 17;
	localparam int IDX_W  = 2;

	localparam logic [IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
	localparam logic [IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_NBR,
		ST_POP,
		ST_OUT
	} lba_state_t;

	// Direction of one neighbor relative to the current pixel
	typedef struct packed {
		logic up;
		logic dn;
		logic lf;
		logic rt;
	} lba_dir_t;

	function automatic lba_dir_t nbr_dir(input logic [3:0] k);
		lba_dir_t d;
		d = '0;
		case (k)
			4'd0: begin d.up = 1'b1; d.lf = 1'b1; end
			4'd1: begin d.up = 1'b1; end
			4'd2: begin d.up = 1'b1; d.rt = 1'b1; end
			4'd3: begin d.lf = 1'b1; end
			4'd4: begin d.rt = 1'b1; end
			4'd5: begin d.dn = 1'b1; d.lf = 1'b1; end
			4'd6: begin d.dn = 1'b1; end
			4'd7: begin d.dn = 1'b1; d.rt = 1'b1; end
			default: d = '0;
		endcase
		return d;
	endfunction

endpackage

/* rtl/lba_ram.sv */
// ----------------------------------------------------------------------------
// lba_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module lba_ram #(
	parameter int AW = 16,
	parameter int DW = 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/largest_blob_area.sv */
// ----------------------------------------------------------------------------
// largest_blob_area: size of the largest 8-connected group of filled pixels
// Loads one pixel per cycle, then scans and flood-fills the stored frame.
// ----------------------------------------------------------------------------
// Load: one pixel transaction per cycle while in_stall is low.
// Search: a scan over every grid cell, plus, for each filled pixel, eight
//   neighbor reads through the pixel RAM read port, a check of the last read,
//   a pick of the next stack entry and a stack pop.
// Result: held on largest_area until taken, then the next frame loads.
// Reset: asynchronous, clears control state; RAM contents are not cleared.
module largest_blob_area
	import lba_pkg::*;
#(
	parameter int MAX_ROWS    = 256,
	parameter int MAX_COLUMNS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                pixel_filled,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [AREA_W-1:0]   largest_area
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int AW = RW + CW;
	localparam int RDW = $clog2(MAX_ROWS + 1);
	localparam int CDW = $clog2(MAX_COLUMNS + 1);
	localparam int REW = (RDW > CFG_W) ? RDW : CFG_W;
	localparam int CEW = (CDW > CFG_W) ? CDW : CFG_W;
	localparam logic [AREA_W-1:0] AREA_SAT = '1;

	// Configuration registers
	logic [CFG_W-1:0] row_cfg_q, col_cfg_q;
	logic [REW-1:0]   rows_x;
	logic [CEW-1:0]   cols_x;
	logic [RDW-1:0]   rows_eff;
	logic [CDW-1:0]   cols_eff;

	// Sequencer
	lba_state_t state_q, state_d;
	logic [RW-1:0]     ld_r_q, scan_r_q, here_r_q;
	logic [CW-1:0]     ld_c_q, scan_c_q, here_c_q;
	logic              scan_done_q;
	logic              chk_s1, nchk_s1;
	logic [AW-1:0]     addr_s1;
	logic [3:0]        k_q;
	logic [AW:0]       sp_q;
	logic [AREA_W-1:0] area_q, best_q;

	// RAM ports
	logic          pix_we, pix_wdata, pix_re, pix_rdata;
	logic [AW-1:0] pix_waddr, pix_raddr;
	logic          stk_we, stk_re;
	logic [AW-1:0] stk_waddr, stk_raddr, stk_rdata;

	// Neighbor decode
	lba_dir_t      dir;
	logic          nbr_ok;
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;
	logic          found;
	logic [RW-1:0] fr;
	logic [CW-1:0] fc;

	// Clamp register values: zero acts as one, large values act as the maximum
	always_comb begin
		rows_x = REW'(row_cfg_q);
		cols_x = CEW'(col_cfg_q);
		if (row_cfg_q == '0) begin
			rows_x = REW'(1);
		end else if (rows_x > REW'(MAX_ROWS)) begin
			rows_x = REW'(MAX_ROWS);
		end
		if (col_cfg_q == '0) begin
			cols_x = CEW'(1);
		end else if (cols_x > CEW'(MAX_COLUMNS)) begin
			cols_x = CEW'(MAX_COLUMNS);
		end
		rows_eff = rows_x[RDW-1:0];
		cols_eff = cols_x[CDW-1:0];
	end

	function automatic logic row_last(input logic [RW-1:0] r, input logic [RDW-1:0] n);
		return ((RDW+1)'(r) + (RDW+1)'(1)) == (RDW+1)'(n);
	endfunction

	function automatic logic col_last(input logic [CW-1:0] c, input logic [CDW-1:0] n);
		return ((CDW+1)'(c) + (CDW+1)'(1)) == (CDW+1)'(n);
	endfunction

	// Neighbor of the current pixel selected by k, with bounds check
	always_comb begin
		dir = nbr_dir(k_q);
		nbr_ok = (k_q < 4'd8);
		nr = here_r_q;
		nc = here_c_q;
		if (dir.up) begin
			nbr_ok = nbr_ok && (here_r_q != '0);
			nr = here_r_q - RW'(1);
		end
		if (dir.dn) begin
			nbr_ok = nbr_ok && !row_last(here_r_q, rows_eff);
			nr = here_r_q + RW'(1);
		end
		if (dir.lf) begin
			nbr_ok = nbr_ok && (here_c_q != '0);
			nc = here_c_q - CW'(1);
		end
		if (dir.rt) begin
			nbr_ok = nbr_ok && !col_last(here_c_q, cols_eff);
			nc = here_c_q + CW'(1);
		end
	end

	assign found = chk_s1 && pix_rdata;
	assign fr = addr_s1[AW-1:CW];
	assign fc = addr_s1[CW-1:0];

	// RAM port steering
	always_comb begin
		pix_we    = 1'b0;
		pix_waddr = addr_s1;
		pix_wdata = 1'b0;
		pix_re    = 1'b0;
		pix_raddr = {nr, nc};
		stk_we    = 1'b0;
		stk_waddr = sp_q[AW-1:0];
		stk_re    = 1'b0;
		stk_raddr = AW'(sp_q - (AW+1)'(1));
		unique case (state_q)
			ST_LOAD: begin
				pix_we    = in_valid;
				pix_waddr = {ld_r_q, ld_c_q};
				pix_wdata = pixel_filled;
			end
			ST_SCAN: begin
				pix_we    = found;
				pix_re    = !scan_done_q;
				pix_raddr = {scan_r_q, scan_c_q};
			end
			ST_NBR: begin
				pix_we = nchk_s1 && pix_rdata;
				stk_we = nchk_s1 && pix_rdata;
				pix_re = nbr_ok;
				stk_re = (k_q == 4'd8) && !nchk_s1 && (sp_q != '0);
			end
			ST_POP: begin
			end
			ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	lba_ram #(.AW(AW), .DW(1)) u_pix_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (pix_wdata),
		.re    (pix_re),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	lba_ram #(.AW(AW), .DW(AW)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (addr_s1),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid && row_last(ld_r_q, rows_eff) && col_last(ld_c_q, cols_eff)
						&& !cfg_we) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (found) begin
					state_d = ST_NBR;
				end else if (!chk_s1 && scan_done_q) begin
					state_d = ST_OUT;
				end
			end
			ST_NBR: begin
				if (k_q == 4'd8 && !nchk_s1) begin
					state_d = (sp_q == '0) ? ST_SCAN : ST_POP;
				end
			end
			ST_POP: state_d = ST_NBR;
			ST_OUT: begin
				if (!out_stall) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes; a write to either dimension register restarts the frame load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_cfg_q <= CFG_W'(1);
			col_cfg_q <= CFG_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_ROW_COUNT) begin
				row_cfg_q <= cfg_data;
			end else if (cfg_index == REG_COLUMN_COUNT) begin
				col_cfg_q <= cfg_data;
			end
		end
	end

	// Datapath and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_r_q      <= '0;
			ld_c_q      <= '0;
			scan_r_q    <= '0;
			scan_c_q    <= '0;
			scan_done_q <= 1'b0;
			here_r_q    <= '0;
			here_c_q    <= '0;
			chk_s1      <= 1'b0;
			nchk_s1     <= 1'b0;
			addr_s1     <= '0;
			k_q         <= '0;
			sp_q        <= '0;
			area_q      <= '0;
			best_q      <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (cfg_we && (cfg_index == REG_ROW_COUNT
							|| cfg_index == REG_COLUMN_COUNT)) begin
						ld_r_q <= '0;
						ld_c_q <= '0;
					end else if (in_valid) begin
						// Advance the raster position; wrap at frame end
						if (col_last(ld_c_q, cols_eff)) begin
							ld_c_q <= '0;
							ld_r_q <= row_last(ld_r_q, rows_eff) ? '0 : ld_r_q + RW'(1);
						end else begin
							ld_c_q <= ld_c_q + CW'(1);
						end
					end
					scan_r_q    <= '0;
					scan_c_q    <= '0;
					scan_done_q <= 1'b0;
					chk_s1      <= 1'b0;
					nchk_s1     <= 1'b0;
					sp_q        <= '0;
					best_q      <= '0;
				end
				ST_SCAN: begin
					if (found) begin
						// Start a new group at the found pixel; resume scan after it
						chk_s1   <= 1'b0;
						here_r_q <= fr;
						here_c_q <= fc;
						area_q   <= AREA_W'(1);
						k_q      <= '0;
						if (col_last(fc, cols_eff)) begin
							scan_c_q    <= '0;
							scan_r_q    <= fr + RW'(1);
							scan_done_q <= row_last(fr, rows_eff);
						end else begin
							scan_c_q    <= fc + CW'(1);
							scan_r_q    <= fr;
							scan_done_q <= 1'b0;
						end
					end else begin
						chk_s1  <= !scan_done_q;
						addr_s1 <= {scan_r_q, scan_c_q};
						if (!scan_done_q) begin
							if (col_last(scan_c_q, cols_eff)) begin
								scan_c_q    <= '0;
								scan_r_q    <= scan_r_q + RW'(1);
								scan_done_q <= row_last(scan_r_q, rows_eff);
							end else begin
								scan_c_q <= scan_c_q + CW'(1);
							end
						end
					end
				end
				ST_NBR: begin
					// Issue one neighbor read per cycle, check the previous one
					if (nchk_s1 && pix_rdata) begin
						sp_q <= sp_q + (AW+1)'(1);
					end
					if (k_q != 4'd8) begin
						nchk_s1 <= nbr_ok;
						addr_s1 <= {nr, nc};
						k_q     <= k_q + 4'd1;
					end else begin
						nchk_s1 <= 1'b0;
						if (!nchk_s1) begin
							if (sp_q == '0) begin
								if (area_q > best_q) begin
									best_q <= area_q;
								end
							end else begin
								sp_q <= sp_q - (AW+1)'(1);
							end
						end
					end
				end
				ST_POP: begin
					here_r_q <= stk_rdata[AW-1:CW];
					here_c_q <= stk_rdata[CW-1:0];
					k_q      <= '0;
					if (area_q != AREA_SAT) begin
						area_q <= area_q + AREA_W'(1);
					end
				end
				ST_OUT: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign in_stall     = (state_q != ST_LOAD);
	assign out_valid    = (state_q == ST_OUT);
	assign largest_area = best_q;

	// Stack is empty whenever a frame loads
	a_sp_empty_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (sp_q == '0))
		else $error("stack not empty during load");

	// A group being filled always holds at least its seed pixel
	a_area_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NBR) |-> (area_q != '0))
		else $error("empty group in fill");

	// Neighbor checks only run inside a fill
	a_nchk_state: assert property (@(posedge clk) disable iff (!arst_n)
		nchk_s1 |-> (state_q == ST_NBR))
		else $error("neighbor check outside fill");

	// A pop always follows a nonempty stack
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NBR && state_d == ST_POP) |-> (sp_q != '0))
		else $error("pop from empty stack");

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking testbench for largest_blob_area
// Streams binary frames through the pixel port and checks each largest
// 8-connected group size against a flood fill kept inside the bench.
// Both handshakes idle at random; grid dimensions change between frames.
// ----------------------------------------------------------------------------
module tb;
	import lba_pkg::*;

	localparam int GRID_MAX    = 256;
	localparam int CELLS       = GRID_MAX * GRID_MAX;
	localparam int SETTLE      = 40;       // idle cycles before a register write
	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_GOAL   = 1850;
	localparam int QUIET_END   = 1450;     // no idling until this many pixels
	localparam int IDLE_PCT    = 23;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic              pixel_filled;
	logic              out_valid;
	logic              out_stall;
	logic [AREA_W-1:0] largest_area;

	largest_blob_area dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .pixel_filled(pixel_filled),
		.out_valid(out_valid), .out_stall(out_stall), .largest_area(largest_area)
	);

	// Shadow of the block: stored frame, visited marks, dimension registers
	bit             frame_pix [CELLS];
	bit             visited   [CELLS];
	logic [CFG_W-1:0] rows_reg;
	logic [CFG_W-1:0] cols_reg;
	int unsigned    load_pos;
	logic [AREA_W-1:0] area_q [$];

	int unsigned cycles;
	int unsigned errors;
	int unsigned pixels_sent;
	bit          idle_en;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > GRID_MAX)
			return GRID_MAX;
		return 32'(v);
	endfunction

	// Flood fill over the stored frame; return the largest group size
	function automatic logic [AREA_W-1:0] largest_group(input int unsigned nr,
			input int unsigned nc);
		int unsigned stk [$];
		int unsigned best, area, here, there, start;
		int r, c, rr, cc;
		best = 0;
		for (int i = 0; i < nr * nc; i++)
			visited[i] = 1'b0;
		for (start = 0; start < nr * nc; start++) begin
			if (!frame_pix[start] || visited[start])
				continue;
			visited[start] = 1'b1;
			stk.push_back(start);
			area = 0;
			while (stk.size() > 0) begin
				here = stk.pop_back();
				r = here / nc;
				c = here % nc;
				area++;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if ((dr == 0 && dc == 0) || rr < 0 || rr >= nr || cc < 0 || cc >= nc)
							continue;
						there = rr * nc + cc;
						if (frame_pix[there] && !visited[there]) begin
							visited[there] = 1'b1;
							stk.push_back(there);
						end
					end
				end
			end
			if (area > best)
				best = area;
		end
		return best[AREA_W-1:0];
	endfunction

	// Record one accepted pixel; queue the area when the frame completes
	function automatic void predict_pixel(input bit p);
		int unsigned total;
		total = clamp_dim(rows_reg) * clamp_dim(cols_reg);
		if (load_pos >= total)
			load_pos = 0;
		frame_pix[load_pos] = p;
		load_pos++;
		if (load_pos == total) begin
			load_pos = 0;
			area_q.push_back(largest_group(clamp_dim(rows_reg), clamp_dim(cols_reg)));
		end
	endfunction

	// Send one pixel transaction; hold valid high across back-to-back items
	task automatic send_pixel(input bit p);
		if (idle_en && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid     <= 1'b1;
		pixel_filled <= p;
		do @(posedge clk); while (in_stall);
		predict_pixel(p);
		pixels_sent++;
	endtask

	// Drop valid, wait for every queued area, then let the block settle
	task automatic drain;
		in_valid <= 1'b0;
		while (area_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we    <= 1'b0;
		// Only the two dimension registers exist; a write restarts the frame
		if (idx == REG_ROW_COUNT)
			rows_reg = val;
		else if (idx == REG_COLUMN_COUNT)
			cols_reg = val;
		else
			return;
		load_pos = 0;
	endtask

	task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
		write_reg(REG_ROW_COUNT, r);
		write_reg(REG_COLUMN_COUNT, c);
	endtask

	// Send one whole frame with fill density in percent
	task automatic send_frame(input int unsigned density);
		int unsigned total;
		total = clamp_dim(rows_reg) * clamp_dim(cols_reg);
		for (int i = 0; i < total; i++)
			send_pixel($urandom_range(99) < density);
	endtask

	task automatic send_bits(input int unsigned n, input logic [63:0] bits);
		for (int i = n - 1; i >= 0; i--)
			send_pixel(bits[i]);
	endtask

	// Result side: randomize stall and check each accepted area
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (area_q.size() == 0) begin
					$display("%0t: unexpected area, expected none, actual %0d",
						$time, largest_area);
					errors++;
				end else begin
					if (largest_area !== area_q[0]) begin
						$display("%0t: largest_area mismatch, expected %0d, actual %0d",
							$time, area_q[0], largest_area);
						errors++;
					end
					void'(area_q.pop_front());
				end
			end
			out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// 1x1 grid straight out of reset: empty and filled
	task automatic test_reset_dims;
		send_bits(4, 64'b0110);
	endtask

	// Small grids: solid, corner-only chain, isolated dots, two runs joined at a corner, empty
	task automatic test_shapes;
		set_dims(9'd3, 9'd3);
		send_bits(9, 64'b111_111_111);
		send_bits(9, 64'b100_010_001);
		send_bits(9, 64'b101_000_101);
		set_dims(9'd2, 9'd4);
		send_bits(8, 64'b1100_0011);
		send_bits(8, 64'b0000_0000);
	endtask

	// Out-of-range values clamp; indexes past the list do nothing
	task automatic test_clamp;
		set_dims(9'd0, 9'd511);
		send_frame(60);
		set_dims(9'd511, 9'd0);
		write_reg(2'd2, 9'h1ff);
		write_reg(2'd3, 9'h0aa);
		send_frame(50);
		set_dims(9'd256, 9'd2);
		send_frame(100);
	endtask

	// A write in the middle of a frame drops the pixels already loaded
	task automatic test_restart;
		set_dims(9'd2, 9'd2);
		send_bits(3, 64'b111);
		write_reg(REG_COLUMN_COUNT, 9'd2);
		send_bits(4, 64'b1001);
	endtask

	// Random dimensions and content; the first stretch runs without any idling
	task automatic test_random;
		logic [CFG_W-1:0] r, c;
		while (pixels_sent < ITEM_GOAL) begin
			idle_en = (pixels_sent >= QUIET_END);
			case ($urandom_range(9))
				0: begin
					r = CFG_W'($urandom_range(511));
					c = CFG_W'($urandom_range(1));
				end
				1: begin
					r = CFG_W'($urandom_range(12, 20));
					c = CFG_W'($urandom_range(12, 20));
				end
				default: begin
					r = CFG_W'($urandom_range(1, 10));
					c = CFG_W'($urandom_range(1, 10));
				end
			endcase
			if ($urandom_range(1))
				set_dims(r, c);
			else begin
				write_reg(REG_COLUMN_COUNT, c);
				write_reg(REG_ROW_COUNT, r);
			end
			// Occasionally break a frame off and restart it
			if ($urandom_range(7) == 0) begin
				repeat ($urandom_range(1, 3)) send_pixel(1'($urandom_range(1)));
				write_reg(REG_ROW_COUNT, r);
			end
			repeat ($urandom_range(1, 4))
				if (pixels_sent < ITEM_GOAL)
					send_frame($urandom_range(100));
		end
		idle_en = 1'b1;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		pixel_filled = 1'b0;
		out_stall    = 1'b0;
		cycles       = 0;
		errors       = 0;
		pixels_sent  = 0;
		idle_en      = 1'b1;
		rows_reg     = 1;
		cols_reg     = 1;
		load_pos     = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_dims();
		test_shapes();
		test_clamp();
		test_restart();
		test_random();

		drain();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
